// ===== sv/gfms_pkg.sv =====
// ----------------------------------------------------------------------------
// gfms_pkg
// Shared types and constants for the gap-filling maximum subarray sum block.
// ----------------------------------------------------------------------------
package gfms_pkg;

  // Result kinds, also used as operation codes between front and back
  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_MAX    = 2'd2
  } kind_t;

  // Control part of one queued operation
  typedef struct packed {
    kind_t kind;
    logic  last;
  } op_ctrl_t;

  // Operation queue depth (power of two, pointers wrap naturally)
  localparam int QUEUE_DEPTH = 4;

  // Most operations one input can produce
  localparam int MAX_OPS = 3;

endpackage

// ===== sv/gfms_front.sv =====
// ----------------------------------------------------------------------------
// gfms_front
// Accepts samples, tracks missing-sample runs and the left neighbor, and turns
// each sample into zero to three operations, one per cycle while not q_full.
// ----------------------------------------------------------------------------
module gfms_front import gfms_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          final_req,
  input  logic                          q_full,
  output logic                          op_valid,
  output op_ctrl_t                      op_ctrl,
  output logic signed [SAMPLE_BITS-1:0] op_val,
  output logic [COUNT_BITS-1:0]         op_cnt
);

  // Sequence state
  logic                          have_left;
  logic signed [SAMPLE_BITS-1:0] left_value;
  logic [COUNT_BITS-1:0]         pending;

  // Operation list of the transaction in flight
  op_ctrl_t                      ops_ctrl [MAX_OPS];
  logic signed [SAMPLE_BITS-1:0] ops_val  [MAX_OPS];
  logic [COUNT_BITS-1:0]         ops_cnt  [MAX_OPS];
  logic [1:0]                    nops;
  logic [1:0]                    pos;

  op_ctrl_t                      ctrl_next [MAX_OPS];
  logic signed [SAMPLE_BITS-1:0] val_next  [MAX_OPS];
  logic [COUNT_BITS-1:0]         cnt_next  [MAX_OPS];
  logic [1:0]                    nops_next;

  logic                          is_miss;
  logic [COUNT_BITS-1:0]         pend_inc;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS:0]   avg_full;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic signed [SAMPLE_BITS-1:0] fill_left;
  logic                          busy;
  logic                          push;
  logic                          accept;

  // Sample classification and fill values
  assign is_miss   = (sample == '1);
  assign pend_inc  = (pending == '1) ? pending : pending + 1'b1;
  assign pair_sum  = (SAMPLE_BITS + 1)'(left_value) + (SAMPLE_BITS + 1)'(sample);
  // arithmetic shift rounds down; add one back for negative odd sums
  assign avg_full  = (pair_sum >>> 1)
                   + {{SAMPLE_BITS{1'b0}}, pair_sum[SAMPLE_BITS] & pair_sum[0]};
  assign avg       = avg_full[SAMPLE_BITS-1:0];
  assign fill_left = have_left ? left_value : '0;

  // Build the operation list for the incoming sample
  always_comb begin
    for (int i = 0; i < MAX_OPS; i++) begin
      ctrl_next[i] = '{kind: KIND_MAX, last: 1'b0};
      val_next[i]  = '0;
      cnt_next[i]  = '0;
    end
    nops_next = 2'd0;
    if (is_miss) begin
      if (final_req) begin
        ctrl_next[0].kind = KIND_FILL;
        val_next[0]       = fill_left;
        cnt_next[0]       = pend_inc;
        ctrl_next[1].kind = KIND_MAX;
        nops_next         = 2'd2;
      end
    end else if (pending != '0) begin
      ctrl_next[0].kind = KIND_FILL;
      val_next[0]       = have_left ? avg : sample;
      cnt_next[0]       = pending;
      ctrl_next[1].kind = KIND_SAMPLE;
      val_next[1]       = sample;
      cnt_next[1]       = COUNT_BITS'(1);
      ctrl_next[2].kind = KIND_MAX;
      nops_next         = final_req ? 2'd3 : 2'd2;
    end else begin
      ctrl_next[0].kind = KIND_SAMPLE;
      val_next[0]       = sample;
      cnt_next[0]       = COUNT_BITS'(1);
      ctrl_next[1].kind = KIND_MAX;
      nops_next         = final_req ? 2'd2 : 2'd1;
    end
    for (int i = 0; i < MAX_OPS; i++) begin
      ctrl_next[i].last = (2'(i) == nops_next - 2'd1);
    end
  end

  // Push sequencing: a new transaction enters as the last operation leaves
  assign busy     = (pos != nops);
  assign push     = busy && !q_full;
  assign in_stall = busy && !(push && (pos + 2'd1 == nops));
  assign accept   = in_valid && !in_stall;

  assign op_valid = busy;
  assign op_ctrl  = ops_ctrl[pos];
  assign op_val   = ops_val[pos];
  assign op_cnt   = ops_cnt[pos];

  // Control and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_left  <= 1'b0;
      left_value <= '0;
      pending    <= '0;
      nops       <= 2'd0;
      pos        <= 2'd0;
    end else if (accept) begin
      nops <= nops_next;
      pos  <= 2'd0;
      if (final_req) begin
        have_left  <= 1'b0;
        left_value <= '0;
        pending    <= '0;
      end else if (is_miss) begin
        pending <= pend_inc;
      end else begin
        have_left  <= 1'b1;
        left_value <= sample;
        pending    <= '0;
      end
    end else if (push) begin
      pos <= pos + 2'd1;
    end
  end

  // Operation list payload
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_OPS; i++) begin
        ops_ctrl[i] <= ctrl_next[i];
        ops_val[i]  <= val_next[i];
        ops_cnt[i]  <= cnt_next[i];
      end
    end
  end

endmodule

// ===== sv/gfms_queue.sv =====
// ----------------------------------------------------------------------------
// gfms_queue
// Small register FIFO between front and back; head is read combinationally.
// ----------------------------------------------------------------------------
module gfms_queue import gfms_pkg::*; #(
  parameter int WIDTH = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_full,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_full = (count == CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/gfms_back.sv =====
// ----------------------------------------------------------------------------
// gfms_back
// Executes queued operations: run-length product, closed-form Kadane update
// with saturation, and the registered result stage.
// ----------------------------------------------------------------------------
module gfms_back import gfms_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24,
  parameter int SUM_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  op_ctrl_t                      op_ctrl,
  input  logic signed [SAMPLE_BITS-1:0] op_val,
  input  logic [COUNT_BITS-1:0]         op_cnt,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic signed [SUM_BITS-1:0]    value,
  output logic [COUNT_BITS-1:0]         repeat_res,
  output logic                          end_of_run
);

  localparam int PW = COUNT_BITS + SAMPLE_BITS + 1;
  localparam int XW = ((PW > SUM_BITS) ? PW : SUM_BITS) + 1;
  localparam logic signed [XW-1:0] SMAX_X =
    {{(XW - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN_X = ~SMAX_X;

  // Clamp a wide value into the sum range
  function automatic logic signed [SUM_BITS-1:0] sat_x(input logic signed [XW-1:0] x);
    logic signed [SUM_BITS-1:0] r;
    if (x > SMAX_X) begin
      r = SMAX_X[SUM_BITS-1:0];
    end else if (x < SMIN_X) begin
      r = SMIN_X[SUM_BITS-1:0];
    end else begin
      r = x[SUM_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a,
    input logic signed [SUM_BITS-1:0] b
  );
    logic signed [XW-1:0] s;
    s = XW'(a) + XW'(b);
    return sat_x(s);
  endfunction

  function automatic logic signed [SUM_BITS-1:0] max0(input logic signed [SUM_BITS-1:0] a);
    return a[SUM_BITS-1] ? '0 : a;
  endfunction

  // Stage A: operation with its run product
  logic                          a_valid;
  op_ctrl_t                      a_ctrl;
  logic signed [SAMPLE_BITS-1:0] a_val;
  logic [COUNT_BITS-1:0]         a_cnt;
  logic signed [PW-1:0]          a_prod;

  // Kadane state
  logic                          started;
  logic signed [SUM_BITS-1:0]    cur_sum;
  logic signed [SUM_BITS-1:0]    best_sum;

  logic                          advance;
  logic                          fire;
  logic signed [SUM_BITS-1:0]    vx;
  logic signed [XW-1:0]          prod_x;
  logic signed [SUM_BITS-1:0]    m_all;
  logic signed [SUM_BITS-1:0]    m_less;
  logic signed [SUM_BITS-1:0]    carry_in;
  logic signed [SUM_BITS-1:0]    cur_next;
  logic signed [SUM_BITS-1:0]    peak;
  logic signed [SUM_BITS-1:0]    best_next;

  assign advance  = !out_valid || !out_stall;
  assign op_ready = !a_valid || advance;
  assign fire     = a_valid && advance;

  // Kadane step for a run of a_cnt copies of a_val
  always_comb begin
    vx       = SUM_BITS'(a_val);
    prod_x   = XW'(a_prod);
    m_all    = sat_x(prod_x);
    m_less   = sat_x(prod_x - XW'(a_val));
    carry_in = started ? max0(cur_sum) : '0;
    if (!a_val[SAMPLE_BITS-1]) begin
      cur_next = sat_add(carry_in, m_all);
      peak     = cur_next;
    end else begin
      cur_next = sat_add(vx, max0(sat_add(carry_in, m_less)));
      peak     = sat_add(carry_in, vx);
    end
    best_next = (!started || (peak > best_sum)) ? peak : best_sum;
  end

  // Control, Kadane state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      started   <= 1'b0;
      cur_sum   <= '0;
      best_sum  <= '0;
    end else begin
      if (op_ready) a_valid <= op_valid;
      if (advance)  out_valid <= a_valid;
      if (fire) begin
        if (a_ctrl.kind == KIND_MAX) begin
          started  <= 1'b0;
          cur_sum  <= '0;
          best_sum <= '0;
        end else begin
          started  <= 1'b1;
          cur_sum  <= cur_next;
          best_sum <= best_next;
        end
      end
    end
  end

  // Stage A payload: one multiply per operation
  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      a_ctrl <= op_ctrl;
      a_val  <= op_val;
      a_cnt  <= op_cnt;
      a_prod <= $signed({1'b0, op_cnt}) * op_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire) begin
      kind       <= a_ctrl.kind;
      end_of_run <= a_ctrl.last;
      if (a_ctrl.kind == KIND_MAX) begin
        value      <= best_sum;
        repeat_res <= '0;
      end else begin
        value      <= vx;
        repeat_res <= a_cnt;
      end
    end
  end

endmodule

// ===== sv/gap_fill_max_subarray_sum.sv =====
// ----------------------------------------------------------------------------
// gap_fill_max_subarray_sum
// Missing-sample recovery with a running maximum subarray sum.
// ----------------------------------------------------------------------------
// Samples equal to -1 are missing. A run of them is reported as one filled
// result (average of its neighbors, or the right neighbor alone) ahead of the
// next valid sample, which follows as its own result. A sample with final_req
// set closes the sequence: a pending run takes the left neighbor (or 0) and
// the saturated maximum subarray sum is reported last. Each input causes n
// results, n from 0 to 3, and the next input is taken as its last operation
// is pushed: the front pushes one operation per cycle while the four-entry
// queue has room, and the back retires one operation per cycle, unless the
// output stalls, through a multiply stage and the Kadane update.
// ----------------------------------------------------------------------------
module gap_fill_max_subarray_sum import gfms_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24,
  parameter int SUM_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          final_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic signed [SUM_BITS-1:0]    value,
  output logic [COUNT_BITS-1:0]         repeat_res,
  output logic                          end_of_run
);

  localparam int CW = $bits(op_ctrl_t);
  localparam int QW = CW + SAMPLE_BITS + COUNT_BITS;

  logic                          f_valid;
  op_ctrl_t                      f_ctrl;
  logic signed [SAMPLE_BITS-1:0] f_val;
  logic [COUNT_BITS-1:0]         f_cnt;
  logic                          q_full;
  logic [QW-1:0]                 q_in;
  logic [QW-1:0]                 q_out;
  logic                          q_valid;
  logic                          q_ready;
  op_ctrl_t                      b_ctrl;
  logic signed [SAMPLE_BITS-1:0] b_val;
  logic [COUNT_BITS-1:0]         b_cnt;

  // Front: classification and run tracking
  gfms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .final_req (final_req),
    .q_full    (q_full),
    .op_valid  (f_valid),
    .op_ctrl   (f_ctrl),
    .op_val    (f_val),
    .op_cnt    (f_cnt)
  );

  // Operation queue
  assign q_in = {f_ctrl, f_val, f_cnt};

  gfms_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_full  (q_full),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_out)
  );

  assign b_ctrl = op_ctrl_t'(q_out[QW-1 -: CW]);
  assign b_val  = q_out[COUNT_BITS +: SAMPLE_BITS];
  assign b_cnt  = q_out[COUNT_BITS-1:0];

  // Back: Kadane execution and results
  gfms_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op_ready   (q_ready),
    .op_ctrl    (b_ctrl),
    .op_val     (b_val),
    .op_cnt     (b_cnt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .repeat_res (repeat_res),
    .end_of_run (end_of_run)
  );

  // The maximum sum always closes its transaction
  a_max_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_MAX) |-> end_of_run && (repeat_res == '0))
    else $error("maximum sum result not last or with nonzero count");

  // A valid sample stands for exactly one recovered sample
  a_sample_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SAMPLE) |-> (repeat_res == COUNT_BITS'(1)))
    else $error("valid sample result with count other than one");

  // A filled run is never empty
  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FILL) |-> (repeat_res != '0))
    else $error("filled run result with zero length");

  // A full queue holds the front's current operation in place
  a_queue_backpressure: assert property (@(posedge clk) disable iff (rst)
    f_valid && q_full |=> f_valid)
    else $error("front dropped an operation while the queue was full");

endmodule
